// ===== rtl/core/segment_access_limit_check_top_macros.svh =====
// Assertion macros shared by the segment access limit check checker.
`ifndef SEGMENT_ACCESS_LIMIT_CHECK_TOP_MACROS_SVH
`define SEGMENT_ACCESS_LIMIT_CHECK_TOP_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define SALC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("segment access limit check assertion failed");

// Clocked assertion that is also checked during reset.
`define SALC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("segment access limit check assertion failed during reset");

`endif

// ===== rtl/core/salc_pkg.sv =====
// Types, codes and constants of the segment access limit check.
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned PageShift = 12;

  localparam logic [31:0] RealModeTop = 32'h0000_FFFF;
  localparam logic [31:0] FullTop     = 32'hFFFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgIs286    = 1'b0,
    CfgProtMode = 1'b1
  } salc_cfg_idx_e;

  typedef enum logic [2:0] {
    SegCs  = 3'd0,
    SegSs  = 3'd1,
    SegDs  = 3'd2,
    SegEs  = 3'd3,
    SegFs  = 3'd4,
    SegGs  = 3'd5,
    SegTr  = 3'd6,
    SegEmu = 3'd7
  } salc_seg_e;

  typedef enum logic [1:0] {
    AccWrite     = 2'd0,
    AccRead      = 2'd1,
    AccRawRead   = 2'd2,
    AccFetch     = 2'd3
  } salc_acc_e;

  typedef enum logic [1:0] {
    FaultNone  = 2'd0,
    FaultGp    = 2'd1,
    FaultNp    = 2'd2,
    FaultBlock = 2'd3
  } salc_fault_e;

  typedef struct packed {
    logic is_286_or_later;
    logic protected_mode;
  } salc_cfg_t;

  typedef struct packed {
    logic [2:0]  segment_reg;
    logic [15:0] selector;
    logic [31:0] offset;
    logic [1:0]  access_kind;
    logic        fault_pending;
    logic        present;
    logic        code_or_data;
    logic        executable;
    logic        expand_or_conform;
    logic        write_or_read;
    logic        granularity;
    logic [19:0] raw_limit;
  } salc_in_t;

  typedef struct packed {
    logic        blocked;
    salc_fault_e fault_kind;
    logic [15:0] error_code;
  } salc_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/salc_eval.sv =====
// Combinational rule evaluation for one access against its descriptor.
`timescale 1ns / 1ps
`default_nettype none

module salc_eval import salc_pkg::*; (
  input  salc_cfg_t cfg_i,
  input  salc_in_t  acc_i,
  output salc_out_t res_o
);

  logic [31:0] limit;
  logic [31:0] upper;
  logic        null_sel;
  logic        bad_fetch;
  logic        bad_write;
  logic        bad_read;
  logic        expand_down;
  logic        limit_fail;

  // Scale the limit by pages and fill the low bits when granular.
  assign limit = acc_i.granularity ? {acc_i.raw_limit, {PageShift{1'b1}}}
                                   : {{PageShift{1'b0}}, acc_i.raw_limit};
  assign upper = acc_i.granularity ? FullTop : RealModeTop;

  assign null_sel = (acc_i.segment_reg != SegCs) && (acc_i.segment_reg != SegSs)
                    && (acc_i.selector[15:3] == '0);

  assign bad_fetch = (acc_i.segment_reg == SegCs) && (acc_i.access_kind == AccFetch)
                     && !(acc_i.executable && acc_i.code_or_data);
  assign bad_write = (acc_i.executable || !acc_i.write_or_read) && acc_i.code_or_data
                     && (acc_i.access_kind == AccWrite);
  assign bad_read  = acc_i.executable && !acc_i.write_or_read && acc_i.code_or_data
                     && (acc_i.access_kind == AccRead);

  assign expand_down = acc_i.code_or_data && !acc_i.executable && acc_i.expand_or_conform;
  assign limit_fail  = expand_down ? ((acc_i.offset <= limit) || (acc_i.offset > upper))
                                   : (acc_i.offset > limit);

  always_comb begin
    res_o = '{blocked: 1'b0, fault_kind: FaultNone, error_code: '0};
    if (!cfg_i.is_286_or_later || (acc_i.segment_reg == SegEmu)) begin
      res_o = '{blocked: 1'b0, fault_kind: FaultNone, error_code: '0};
    end else if (acc_i.fault_pending) begin
      res_o = '{blocked: 1'b1, fault_kind: FaultBlock, error_code: '0};
    end else if (!cfg_i.protected_mode) begin
      if (acc_i.offset > RealModeTop) begin
        res_o = '{blocked: 1'b1, fault_kind: FaultBlock, error_code: '0};
      end
    end else if (null_sel) begin
      res_o = '{blocked: 1'b1, fault_kind: FaultGp, error_code: acc_i.selector};
    end else if (!acc_i.present) begin
      // Not present outranks the type and limit rules.
      res_o = '{blocked: 1'b1, fault_kind: FaultNp, error_code: acc_i.selector};
    end else if (bad_fetch || bad_write || bad_read || limit_fail) begin
      res_o = '{blocked: 1'b1, fault_kind: FaultGp, error_code: acc_i.selector};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/segment_access_limit_check_top.sv =====
// Top level of the segment access limit check: handshake, config and pipeline.
//
// Use: every memory access of the emulated core is sent as one beat on the
// input channel (in_valid_i / in_ready_o / in_data_i) carrying the segment
// register, selector, offset, access kind and cached descriptor bits. Each
// input beat yields exactly one result beat on the output channel
// (out_valid_o / out_ready_i / out_data_o): blocked, fault kind, error code.
// Path: a beat accepted into the input register passes the rule logic, and
// its result lands in the result register, from which it is offered.
// Throughput: one beat per cycle while the receiver keeps out_ready_i high,
// set by the single pass of rule logic between the input register and the
// result register.
// Config: the write port (cfg_we_i, cfg_idx_i, cfg_wdata_i) sets the 286 flag
// and the protected-mode flag; write it only while no beat is in flight.
// Reset: both pipeline stages empty, 286 flag set, protected mode clear.
// Stall: when the receiver holds out_ready_i low the result register holds
// its beat, the input register takes one more beat if it is empty, and then
// in_ready_o drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module segment_access_limit_check_top import salc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  salc_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output salc_out_t          out_data_o
);

  salc_cfg_t cfg_q;
  logic      in_vld_q;
  salc_in_t  in_q;
  logic      out_vld_q;
  salc_out_t out_q;
  salc_out_t res_d;
  logic      out_take;

  // Config registers: the user must write them only while idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{is_286_or_later: 1'b1, protected_mode: 1'b0};
    end else if (cfg_we_i) begin
      unique case (salc_cfg_idx_e'(cfg_idx_i))
        CfgIs286:    cfg_q.is_286_or_later <= cfg_wdata_i;
        CfgProtMode: cfg_q.protected_mode  <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // Result stage can take a beat when empty or draining this cycle.
  assign out_take   = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || out_take;

  // Input register: hold the beat until the result stage takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  salc_eval u_eval (
    .cfg_i (cfg_q),
    .acc_i (in_q),
    .res_o (res_d)
  );

  // Result register: advance when the receiver drains it or it is empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_take) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q && out_take) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/salc_checker.sv =====
// Port-level checker for the segment access limit check, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_access_limit_check_top_macros.svh"

module salc_checker import salc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [CfgIdxW-1:0] cfg_idx_i,
  input logic               cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input salc_in_t           in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input salc_out_t          out_data_o
);

  logic unused_ok;
  assign unused_ok = cfg_we_i ^ (^cfg_idx_i) ^ cfg_wdata_i ^ in_valid_i ^ in_ready_o
                     ^ (^in_data_i);

  // A stalled result beat stays offered.
  `SALC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  // Blocked exactly when some fault kind is reported.
  `SALC_ASSERT(a_blocked_kind, clk_i, rst_ni,
    out_valid_o |-> (out_data_o.blocked == (out_data_o.fault_kind != FaultNone)))

  // Error code only accompanies a general protection or not-present fault.
  `SALC_ASSERT(a_code_zero, clk_i, rst_ni,
    out_valid_o && (out_data_o.fault_kind == FaultNone ||
    out_data_o.fault_kind == FaultBlock) |-> out_data_o.error_code == '0)

  // Nothing is offered in the cycle after reset is seen held.
  `SALC_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind segment_access_limit_check_top salc_checker u_salc_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the segment access limit check top level.
`timescale 1ns / 1ps

module tb_top;
  import salc_pkg::*;

  // Half clock period, watchdog limit and the length of the long receiver hold-off.
  localparam int ClkHalf       = 6;
  localparam int CycleLimit    = 200000;
  localparam int HoldOffCycles = 64;

  // Descriptor bit sets, packed as {present, code_or_data, executable,
  // expand_or_conform, write_or_read, granularity}.
  localparam logic [5:0] DescDataRw  = 6'b110010;
  localparam logic [5:0] DescDataRwG = 6'b110011;
  localparam logic [5:0] DescDataRo  = 6'b110000;
  localparam logic [5:0] DescCodeXo  = 6'b111000;
  localparam logic [5:0] DescCodeXr  = 6'b111010;
  localparam logic [5:0] DescSystem  = 6'b101000;
  localparam logic [5:0] DescExpDn   = 6'b110110;
  localparam logic [5:0] DescExpDnG  = 6'b110111;
  localparam logic [5:0] DescAbsent  = 6'b010010;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = CfgIs286;
  logic               cfg_wdata_i = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  salc_in_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  salc_out_t          out_data_o;

  // Mirror of the two mode registers, updated with every write.
  logic      mode_is_286  = 1'b1;
  logic      mode_prot    = 1'b0;

  // Verdicts predicted for accepted beats, oldest first.
  salc_out_t expected_verdicts[$];
  salc_out_t oldest_verdict;

  int unsigned cycle_count     = 0;
  int unsigned mismatch_count  = 0;
  int unsigned verdicts_seen   = 0;
  int unsigned gp_seen         = 0;
  int unsigned np_seen         = 0;
  int unsigned block_seen      = 0;
  int          burst_left      = 0;
  int          rx_mode         = 0;
  int          rx_left         = 0;
  bit          hold_off_req    = 1'b0;

  segment_access_limit_check_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin : clock_gen
    forever #ClkHalf clk_i = ~clk_i;
  end

  // Watchdog: a stuck handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d verdicts still owed",
               cycle_count, expected_verdicts.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Work out the verdict for one access under the current mode registers.
  // Rules are applied in priority order; the first that fires wins.
  function automatic salc_out_t judge_access(salc_in_t a);
    salc_out_t   v;
    logic [31:0] eff_limit;
    logic [31:0] top;
    v = '{blocked: 1'b0, fault_kind: FaultNone, error_code: 16'h0000};
    // Pre-286 cores and direct emulator accesses skip every check.
    if (!mode_is_286 || a.segment_reg == SegEmu) return v;
    // A fault already raised this instruction just blocks.
    if (a.fault_pending) begin
      v.blocked    = 1'b1;
      v.fault_kind = FaultBlock;
      return v;
    end
    // Real mode: only the 64K wrap matters.
    if (!mode_prot) begin
      if (a.offset > RealModeTop) begin
        v.blocked    = 1'b1;
        v.fault_kind = FaultBlock;
      end
      return v;
    end
    // From here on every fault carries the selector as its error code.
    v.error_code = a.selector;
    v.blocked    = 1'b1;
    v.fault_kind = FaultGp;
    if (a.segment_reg != SegCs && a.segment_reg != SegSs && a.selector[15:3] == '0)
      return v;
    if (!a.present) begin
      v.fault_kind = FaultNp;
      return v;
    end
    if (a.segment_reg == SegCs && a.access_kind == AccFetch &&
        !(a.executable && a.code_or_data))
      return v;
    if ((a.executable || !a.write_or_read) && a.code_or_data && a.access_kind == AccWrite)
      return v;
    if (a.executable && !a.write_or_read && a.code_or_data && a.access_kind == AccRead)
      return v;
    eff_limit = a.granularity ? {a.raw_limit, 12'hFFF} : {12'h000, a.raw_limit};
    if (a.code_or_data && !a.executable && a.expand_or_conform) begin
      // Expand-down: valid offsets sit strictly above the limit.
      top = a.granularity ? FullTop : RealModeTop;
      if (a.offset <= eff_limit || a.offset > top) return v;
    end else if (a.offset > eff_limit) begin
      return v;
    end
    return '{blocked: 1'b0, fault_kind: FaultNone, error_code: 16'h0000};
  endfunction

  function automatic salc_in_t make_access(salc_seg_e seg, logic [15:0] sel,
                                           logic [31:0] off, salc_acc_e kind,
                                           logic [5:0] desc, logic [19:0] lim);
    salc_in_t a;
    a.segment_reg       = seg;
    a.selector          = sel;
    a.offset            = off;
    a.access_kind       = kind;
    a.fault_pending     = 1'b0;
    {a.present, a.code_or_data, a.executable,
     a.expand_or_conform, a.write_or_read, a.granularity} = desc;
    a.raw_limit         = lim;
    return a;
  endfunction

  // Random access, biased toward well-formed descriptors and offsets that
  // land right at the limit edges, with a share of null, absent and
  // pending cases mixed in.
  function automatic salc_in_t random_access();
    salc_in_t    a;
    logic [31:0] eff_limit;
    a.segment_reg = ($urandom_range(0, 15) == 0) ? SegEmu : salc_seg_e'($urandom_range(0, 6));
    a.selector    = 16'($urandom);
    if ($urandom_range(0, 9) == 0) a.selector[15:3] = '0;
    a.access_kind       = salc_acc_e'($urandom_range(0, 3));
    a.fault_pending     = ($urandom_range(0, 15) == 0);
    a.present           = ($urandom_range(0, 11) != 0);
    a.code_or_data      = ($urandom_range(0, 7) != 0);
    a.executable        = 1'($urandom_range(0, 1));
    a.expand_or_conform = 1'($urandom_range(0, 1));
    a.write_or_read     = 1'($urandom_range(0, 1));
    a.granularity       = 1'($urandom_range(0, 1));
    // Half the code-segment beats are proper fetches from code.
    if (a.segment_reg == SegCs && $urandom_range(0, 1) == 1) begin
      a.access_kind  = AccFetch;
      a.executable   = 1'b1;
      a.code_or_data = 1'b1;
    end
    case ($urandom_range(0, 3))
      0:       a.raw_limit = 20'($urandom);
      1:       a.raw_limit = 20'($urandom_range(0, 255));
      2:       a.raw_limit = 20'hFFFFF;
      default: a.raw_limit = 20'($urandom_range(0, 20'h0FFFF));
    endcase
    eff_limit = a.granularity ? {a.raw_limit, 12'hFFF} : {12'h000, a.raw_limit};
    case ($urandom_range(0, 5))
      0:       a.offset = $urandom;
      1:       a.offset = eff_limit + 32'($urandom_range(0, 4)) - 32'd2;
      2:       a.offset = RealModeTop + 32'($urandom_range(0, 4)) - 32'd2;
      3:       a.offset = $urandom_range(0, 16'hFFFF);
      4:       a.offset = 32'h0;
      default: a.offset = FullTop - 32'($urandom_range(0, 2));
    endcase
    return a;
  endfunction

  // Offer one beat; bursts of back-to-back beats alternate with idle gaps.
  // The verdict is queued at the edge where the beat is taken.
  task automatic send_access(salc_in_t a);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= a;
    do @(posedge clk_i); while (!in_ready_o);
    expected_verdicts.push_back(judge_access(a));
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_access(random_access());
  endtask

  // Drop valid and wait until every owed verdict has come back.
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write both mode registers while nothing is in flight.
  task automatic set_mode(logic is_286, logic prot);
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgIs286;
    cfg_wdata_i <= is_286;
    @(negedge clk_i);
    cfg_idx_i   <= CfgProtMode;
    cfg_wdata_i <= prot;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_is_286 = is_286;
    mode_prot   = prot;
  endtask

  // Receiver: ready follows a mode redrawn at random intervals (always ready,
  // mostly ready, mostly stalled). A hold-off request keeps ready low for a long
  // stretch so the pipeline fills and stalls its input.
  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        case (rx_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Check every result beat against the oldest owed verdict.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        $error("result beat with no verdict owed: blocked %0d fault_kind %0d error_code %h",
               out_data_o.blocked, out_data_o.fault_kind, out_data_o.error_code);
        mismatch_count++;
      end else begin
        oldest_verdict = expected_verdicts.pop_front();
        verdicts_seen++;
        case (oldest_verdict.fault_kind)
          FaultGp:    gp_seen++;
          FaultNp:    np_seen++;
          FaultBlock: block_seen++;
          default:    ;
        endcase
        if (out_data_o.blocked !== oldest_verdict.blocked) begin
          $error("blocked: expected %0d, got %0d", oldest_verdict.blocked, out_data_o.blocked);
          mismatch_count++;
        end
        if (out_data_o.fault_kind !== oldest_verdict.fault_kind) begin
          $error("fault_kind: expected %0d, got %0d",
                 oldest_verdict.fault_kind, out_data_o.fault_kind);
          mismatch_count++;
        end
        if (out_data_o.error_code !== oldest_verdict.error_code) begin
          $error("error_code: expected %h, got %h",
                 oldest_verdict.error_code, out_data_o.error_code);
          mismatch_count++;
        end
      end
    end
  end

  // Reset state is 286 checks on, real mode: probe the 64K wrap, a
  // pending fault, and an emulator access that outranks the pending flag.
  task automatic test_reset_defaults();
    salc_in_t a;
    send_access(make_access(SegDs, 16'h0010, 32'h0000_FFFF, AccRead, DescDataRw, 20'h0FFFF));
    send_access(make_access(SegDs, 16'h0010, 32'h0001_0000, AccWrite, DescDataRw, 20'h0FFFF));
    send_access(make_access(SegEs, 16'h0000, FullTop, AccRawRead, DescAbsent, 20'h00000));
    a = make_access(SegCs, 16'h0008, 32'h0, AccFetch, DescCodeXr, 20'hFFFFF);
    a.fault_pending = 1'b1;
    send_access(a);
    a = make_access(SegEmu, 16'h0000, FullTop, AccWrite, DescAbsent, 20'h00000);
    a.fault_pending = 1'b1;
    send_access(a);
  endtask

  // Pre-286 core in protected mode: even a null, pending access passes.
  task automatic test_pre_286_bypass();
    salc_in_t a;
    set_mode(1'b0, 1'b1);
    a = make_access(SegDs, 16'h0000, FullTop, AccWrite, DescAbsent, 20'h00000);
    a.fault_pending = 1'b1;
    send_access(a);
  endtask

  // Protected mode: null selectors, absent segments, type rules, and the
  // limit rules with and without granularity, expand-down included.
  task automatic test_protected_rules();
    set_mode(1'b1, 1'b1);
    // Null selector with nonzero RPL in a data register, and in TR.
    send_access(make_access(SegDs, 16'h0003, 32'h0, AccRead, DescDataRw, 20'hFFFFF));
    send_access(make_access(SegTr, 16'h0000, 32'h0, AccRead, DescDataRw, 20'hFFFFF));
    // Null selector in SS is allowed through.
    send_access(make_access(SegSs, 16'h0000, 32'h0, AccWrite, DescDataRw, 20'hFFFFF));
    send_access(make_access(SegDs, 16'h0010, 32'h0, AccRead, DescAbsent, 20'hFFFFF));
    // Fetch rules: from data, from a system descriptor, from code at the limit.
    send_access(make_access(SegCs, 16'h0008, 32'h0, AccFetch, DescDataRw, 20'hFFFFF));
    send_access(make_access(SegCs, 16'h0008, 32'h0, AccFetch, DescSystem, 20'hFFFFF));
    send_access(make_access(SegCs, 16'hFFFF, 32'hFFFF, AccFetch, DescCodeXo, 20'h0FFFF));
    // Write to code, write to read-only data, read of execute-only code.
    send_access(make_access(SegDs, 16'h0018, 32'h0, AccWrite, DescCodeXr, 20'hFFFFF));
    send_access(make_access(SegDs, 16'h0020, 32'h0, AccWrite, DescDataRo, 20'hFFFFF));
    send_access(make_access(SegFs, 16'h0028, 32'h0, AccRead, DescCodeXo, 20'hFFFFF));
    // Unchecked read of execute-only code, and a write through a system
    // descriptor: both skip the type rules.
    send_access(make_access(SegGs, 16'h0030, 32'h10, AccRawRead, DescCodeXo, 20'h000FF));
    send_access(make_access(SegEs, 16'h0038, 32'h10, AccWrite, DescSystem, 20'h000FF));
    // Page granularity: one page plus the low 4K.
    send_access(make_access(SegDs, 16'h0040, 32'h1FFF, AccRead, DescDataRwG, 20'h00001));
    send_access(make_access(SegDs, 16'h0040, 32'h2000, AccRead, DescDataRwG, 20'h00001));
    // Expand-down: at the limit, just above it, and past the 64K top.
    send_access(make_access(SegSs, 16'h0048, 32'h0FFF, AccWrite, DescExpDn, 20'h00FFF));
    send_access(make_access(SegSs, 16'h0048, 32'h1000, AccWrite, DescExpDn, 20'h00FFF));
    send_access(make_access(SegSs, 16'h0048, 32'h1_0000, AccRead, DescExpDn, 20'h00FFF));
    // Expand-down with a full 4G limit leaves no valid offset.
    send_access(make_access(SegDs, 16'h0050, FullTop, AccRead, DescExpDnG, 20'hFFFFF));
    // Zero limit: only offset 0 is valid.
    send_access(make_access(SegFs, 16'h0058, 32'h1, AccRead, DescDataRw, 20'h00000));
    send_access(make_access(SegGs, 16'h0060, 32'h0, AccRead, DescDataRw, 20'h00000));
  endtask

  // Random beats under all four mode settings, protected mode weighted most.
  task automatic test_random_sweep();
    set_mode(1'b1, 1'b1);
    send_random(300);
    set_mode(1'b1, 1'b0);
    send_random(150);
    set_mode(1'b0, 1'b1);
    send_random(50);
    set_mode(1'b0, 1'b0);
    send_random(50);
  endtask

  // Hold the receiver off while beats keep coming; the input must stall.
  task automatic test_backpressure();
    set_mode(1'b1, 1'b1);
    hold_off_req = 1'b1;
    send_random(50);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_pre_286_bypass();
    test_protected_rules();
    test_random_sweep();
    test_backpressure();
    // Drain what is owed, then keep watching for any stray beat.
    wait_quiet();
    repeat (4) @(posedge clk_i);
    $display("Checked %0d access verdicts over all four mode settings", verdicts_seen);
    $display("  %0d general protection, %0d not present, %0d blocked without fault",
             gp_seen, np_seen, block_seen);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== segment_access_limit_check_top.f =====
+incdir+rtl/core
rtl/core/salc_pkg.sv
rtl/core/salc_eval.sv
rtl/core/segment_access_limit_check_top.sv
rtl/core/salc_checker.sv
test/tb_top.sv
